[sv/rgbcf_pkg.sv]
// shared types and constants for the rgb 3x3 convolution filter
`default_nettype none
package rgbcf_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COEF_BITS  = 8;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int DIV_W      = 10;
  localparam int ACC_W      = 20;
  localparam int QUO_W      = 19;
  localparam int PROD_W     = COEF_BITS + 9;
  localparam int NLANES     = 3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_WIDTH    = 3'd0;
  localparam cfg_idx_t REG_HEIGHT   = 3'd1;
  localparam cfg_idx_t REG_COEF_TOP = 3'd2;
  localparam cfg_idx_t REG_COEF_MID = 3'd3;
  localparam cfg_idx_t REG_COEF_BOT = 3'd4;
  localparam cfg_idx_t REG_DIVISOR  = 3'd5;

  typedef logic [8:0][7:0] nine_bytes_t;
  typedef logic [8:0][COEF_BITS-1:0] nine_coefs_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } lane_ctl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] res;
  } lane_sts_t;

  typedef enum logic [1:0] {L_IDLE, L_MAC, L_DIV, L_DONE} lane_state_t;
  typedef enum logic [2:0] {S_IDLE, S_READ, S_PICK, S_CALC, S_SEND} top_state_t;
endpackage
`default_nettype wire

[sv/rgbcf_linebuf.sv]
// two-line pixel buffer, one registered read and one write per cycle
`default_nettype none
module rgbcf_linebuf
  import rgbcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]            rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [63:0]       wr_data
);
  logic [63:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[sv/rgbcf_lane.sv]
// one channel lane: serial multiply-accumulate, restoring divide, clamp
`default_nettype none
module rgbcf_lane
  import rgbcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lane_ctl_t   ctl,
  input  wire nine_bytes_t px,
  input  wire nine_coefs_t coefs,
  output lane_sts_t        sts
);
  lane_state_t state_r, state_nxt;
  nine_bytes_t px_r;
  logic [3:0] k_r;
  logic [4:0] cnt_r;
  logic signed [ACC_W-1:0] acc_r, acc_sum;
  logic signed [PROD_W-1:0] prod;
  logic [QUO_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r, div_r;
  logic [DIV_W:0] rem_sh, rem_sub;
  logic ge;

  always_comb begin
    prod    = PROD_W'($signed({1'b0, px_r[k_r]})) * PROD_W'($signed(coefs[k_r]));
    acc_sum = acc_r + ACC_W'(prod);
    rem_sh  = {rem_r, quo_r[QUO_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: if (ctl.start) state_nxt = L_MAC;
      L_MAC: begin
        if (k_r == 4'd8) state_nxt = L_DIV;
      end
      L_DIV: if (cnt_r == 5'(QUO_W - 1)) state_nxt = L_DONE;
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    sts.done = (state_r == L_DONE);
    sts.res  = (quo_r > QUO_W'(255)) ? 8'hFF : quo_r[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        px_r  <= px;
        div_r <= (ctl.divisor == '0) ? DIV_W'(1) : ctl.divisor;
        k_r   <= '0;
        acc_r <= '0;
      end
      L_MAC: begin
        acc_r <= acc_sum;
        k_r   <= k_r + 4'd1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= acc_sum[ACC_W-1] ? '0 : acc_sum[QUO_W-1:0];
      end
      L_DIV: begin
        rem_r <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[sv/rgb_3x3_convolution_filter.sv]
// top level: raster window, line buffers, three channel lanes and result merge
// flow: read once per accepted pixel, then per result: pick, 9 serial
// multiply-accumulate steps, 19 divide steps, done, send
// each pixel gives n = 0..4 results; no new pixel is taken until all are sent
// reset: synchronous active low; registers return to defaults, position to 0
// line buffer contents are not cleared
`default_nettype none
module rgb_3x3_convolution_filter
  import rgbcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // pixel_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // out_col, out_row, pixel_out, zero pad
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  top_state_t state_r, state_nxt;
  logic [WREG_W-1:0] width_r, wc;
  logic [HREG_W-1:0] height_r, hc;
  logic [23:0] coef_r [3];
  logic [DIV_W-1:0] divisor_r;
  logic [COL_W-1:0] col_r, cur_c_r, c_acc;
  logic [ROW_W-1:0] row_r, cur_r_r, r_acc;
  logic [HREG_W-1:0] r_inc;
  logic [WREG_W-1:0] c_next;
  logic [HREG_W-1:0] r_next;
  logic [31:0] pix_r;
  logic [31:0] win_r [9];
  logic [3:0] flags_r, flags_nxt;
  logic [1:0] kind;
  logic have;
  logic [63:0] rd_data;
  logic accept, last_col, last_row;
  logic [1:0] rs [3];
  logic [1:0] cs [3];
  nine_bytes_t nb [NLANES];
  nine_coefs_t coefs;
  lane_ctl_t ctl;
  lane_sts_t sts [NLANES];
  logic [COL_W-1:0] res_col_r;
  logic [ROW_W-1:0] res_row_r;
  logic [7:0] ctr_byte_r;
  logic last_r;
  logic [31:0] pix_out_r;
  logic out_valid_r;

  assign cfg_ready = 1'b1;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    wc = (width_r == '0) ? WREG_W'(1)
       : (width_r > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : width_r;
    hc = (height_r == '0) ? HREG_W'(1)
       : (height_r > HREG_W'(MAX_HEIGHT)) ? HREG_W'(MAX_HEIGHT) : height_r;
    c_acc = col_r;
    r_inc = {1'b0, row_r};
    if ({1'b0, col_r} >= wc) begin
      c_acc = '0;
      r_inc = {1'b0, row_r} + HREG_W'(1);
    end
    r_acc = (r_inc >= hc) ? '0 : r_inc[ROW_W-1:0];
    last_col = ({1'b0, cur_c_r} == wc - WREG_W'(1));
    last_row = ({1'b0, cur_r_r} == hc - HREG_W'(1));
    c_next = {1'b0, cur_c_r} + WREG_W'(1);
    r_next = {1'b0, cur_r_r} + HREG_W'(1);
  end

  rgbcf_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c_acc),
    .rd_data (rd_data),
    .wr_en   (state_r == S_READ),
    .wr_addr (cur_c_r),
    .wr_data ({rd_data[31:0], pix_r})
  );

  always_comb begin
    have = |flags_r;
    kind = 2'd3;
    if (flags_r[0]) kind = 2'd0;
    else if (flags_r[1]) kind = 2'd1;
    else if (flags_r[2]) kind = 2'd2;
    flags_nxt = flags_r;
    flags_nxt[kind] = 1'b0;
    if (!kind[1]) begin
      rs[0] = (cur_r_r == ROW_W'(1)) ? 2'd1 : 2'd0;
      rs[1] = 2'd1;
      rs[2] = 2'd2;
    end else begin
      rs[0] = (cur_r_r == '0) ? 2'd2 : 2'd1;
      rs[1] = 2'd2;
      rs[2] = 2'd2;
    end
    if (!kind[0]) begin
      cs[0] = (cur_c_r == COL_W'(1)) ? 2'd1 : 2'd0;
      cs[1] = 2'd1;
      cs[2] = 2'd2;
    end else begin
      cs[0] = (cur_c_r == '0) ? 2'd2 : 2'd1;
      cs[1] = 2'd2;
      cs[2] = 2'd2;
    end
    for (int l = 0; l < NLANES; l++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          nb[l][i*3+j] = win_r[4'(rs[2-i]) * 4'd3 + 4'(cs[2-j])][8*(l+1) +: 8];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coefs[i*3+j] = coef_r[i][j*COEF_BITS +: COEF_BITS];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: state_nxt = S_PICK;
      S_PICK: state_nxt = have ? S_CALC : S_IDLE;
      S_CALC: if (sts[0].done) state_nxt = S_SEND;
      S_SEND: if (out_tready) state_nxt = S_PICK;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == S_IDLE);
    ctl.start   = (state_r == S_PICK) && have;
    ctl.divisor = divisor_r;
    out_tvalid  = out_valid_r;
    out_tlast   = last_r;
    out_tdata   = {1'b0, pix_out_r, res_row_r, res_col_r};
  end

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    rgbcf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .px    (nb[l]),
      .coefs (coefs),
      .sts   (sts[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WREG_W'(640);
      height_r    <= HREG_W'(480);
      coef_r[0]   <= '0;
      coef_r[1]   <= 24'd256;
      coef_r[2]   <= '0;
      divisor_r   <= DIV_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_WIDTH:    width_r   <= cfg_data[WREG_W-1:0];
          REG_HEIGHT:   height_r  <= cfg_data[HREG_W-1:0];
          REG_COEF_TOP: coef_r[0] <= cfg_data;
          REG_COEF_MID: coef_r[1] <= cfg_data;
          REG_COEF_BOT: coef_r[2] <= cfg_data;
          REG_DIVISOR:  divisor_r <= cfg_data[DIV_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cur_c_r <= c_acc;
            cur_r_r <= r_acc;
            pix_r   <= in_tdata;
          end
        end
        S_READ: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k*3]   <= win_r[k*3+1];
            win_r[k*3+1] <= win_r[k*3+2];
          end
          win_r[2] <= rd_data[63:32];
          win_r[5] <= rd_data[31:0];
          win_r[8] <= pix_r;
          flags_r <= {last_row && last_col, last_row && (cur_c_r != '0),
                      (cur_r_r != '0) && last_col, (cur_r_r != '0) && (cur_c_r != '0)};
          if (c_next >= wc) begin
            col_r <= '0;
            row_r <= (r_next >= hc) ? '0 : r_next[ROW_W-1:0];
          end else begin
            col_r <= c_next[COL_W-1:0];
            row_r <= cur_r_r;
          end
        end
        S_PICK: begin
          if (have) begin
            flags_r    <= flags_nxt;
            last_r     <= (flags_nxt == '0);
            res_col_r  <= kind[0] ? cur_c_r : cur_c_r - COL_W'(1);
            res_row_r  <= kind[1] ? cur_r_r : cur_r_r - ROW_W'(1);
            ctr_byte_r <= win_r[4'(rs[1]) * 4'd3 + 4'(cs[1])][7:0];
          end
        end
        S_CALC: begin
          if (sts[0].done) begin
            pix_out_r   <= {sts[2].res, sts[1].res, sts[0].res, ctr_byte_r};
            out_valid_r <= 1'b1;
          end
        end
        S_SEND: begin
          if (out_tready) out_valid_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/rgbcf_checker.sv]
// port-level checker for the convolution filter and its bind
`default_nettype none
module rgbcf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result request dropped or changed while stalled");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("second request taken before window load");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
endmodule

bind rgb_3x3_convolution_filter rgbcf_checker u_rgbcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
